>>> design/ictf_pkg.sv
// ictf_pkg: shared types, constants and helpers of the complementary tilt filter
// used by the cordic cell, the multiplier unit and the top level
// no dependencies
`default_nettype none

package ictf_pkg;

    // fixed point formats
    localparam int unsigned ANGLE_FRAC = 16;
    localparam int unsigned ACC_FRAC = 24;
    localparam int unsigned STEP_SHIFT = ACC_FRAC - ANGLE_FRAC;
    localparam int unsigned WEIGHT_FRAC = 16;
    localparam int unsigned TABLE_LEN = 24;
    localparam int unsigned CORDIC_STEPS_DEF = 16;

    localparam int unsigned EST_W = 26;
    localparam int unsigned ACC_W = 25;
    localparam int unsigned G_W = 30;
    localparam int unsigned PROD_W = 53;

    localparam logic signed [33:0] Z180 = 34'sd3019898880;
    localparam logic signed [33:0] Z_HALF = 34'sd1 <<< (STEP_SHIFT - 1);
    localparam logic signed [33:0] ACC_LIM = 34'sd11796480;
    localparam logic signed [30:0] EST_LIM = 31'sd23592960;

    // configuration register indexes
    localparam logic [1:0] REG_BLEND_WEIGHT = 2'd0;
    localparam logic [1:0] REG_GYRO_STEP_SCALE = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GYRO,
        ST_WAIT,
        ST_BLEND,
        ST_LAST,
        ST_OUT
    } ictf_state_t;

    typedef enum logic {
        OP_GYRO,
        OP_BLEND
    } mul_op_t;

    typedef struct packed {
        mul_op_t    op;
        logic [1:0] axis;
    } mul_tag_t;

    typedef struct packed {
        logic              zero;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [33:0] z;
    } cordic_lane_t;

    // atan(2^-i) in degrees, q.24
    function automatic logic signed [33:0] atan_step(int unsigned i);
        logic signed [33:0] r;
        case (i)
            0:  r = 34'sd754974720;
            1:  r = 34'sd445687602;
            2:  r = 34'sd235489088;
            3:  r = 34'sd119537938;
            4:  r = 34'sd60000934;
            5:  r = 34'sd30029717;
            6:  r = 34'sd15018523;
            7:  r = 34'sd7509720;
            8:  r = 34'sd3754917;
            9:  r = 34'sd1877466;
            10: r = 34'sd938734;
            11: r = 34'sd469367;
            12: r = 34'sd234684;
            13: r = 34'sd117342;
            14: r = 34'sd58671;
            15: r = 34'sd29335;
            16: r = 34'sd14668;
            17: r = 34'sd7334;
            18: r = 34'sd3667;
            19: r = 34'sd1833;
            20: r = 34'sd917;
            21: r = 34'sd458;
            22: r = 34'sd229;
            23: r = 34'sd115;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    // pre-rotation into the right half plane, operands scaled by 2^14
    function automatic cordic_lane_t cordic_init(logic signed [16:0] y, logic signed [16:0] x);
        cordic_lane_t l;
        logic signed [31:0] xs;
        logic signed [31:0] ys;
        xs = 32'(x) <<< 14;
        ys = 32'(y) <<< 14;
        l.zero = (x == 17'sd0) && (y == 17'sd0);
        if (x < 17'sd0)
        begin
            l.z = (y >= 17'sd0) ? Z180 : -Z180;
            l.x = -xs;
            l.y = -ys;
        end
        else
        begin
            l.z = 34'sd0;
            l.x = xs;
            l.y = ys;
        end
        return l;
    endfunction

    // round the q.24 accumulator to angle format and clamp to +-180
    function automatic logic signed [ACC_W-1:0] cordic_finish(cordic_lane_t l);
        logic signed [33:0] zr;
        zr = ($signed(l.z) + Z_HALF) >>> STEP_SHIFT;
        if (l.zero)
            zr = 34'sd0;
        else if (zr > ACC_LIM)
            zr = ACC_LIM;
        else if (zr < -ACC_LIM)
            zr = -ACC_LIM;
        return ACC_W'(zr);
    endfunction

endpackage

`default_nettype wire

>>> design/ictf_cordic_cell.sv
// ictf_cordic_cell: one vectoring cordic iteration for the roll and pitch lanes
// depends on ictf_pkg
`default_nettype none

module ictf_cordic_cell
    import ictf_pkg::*;
#(
    parameter int unsigned STEP = 0
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         valid_in,
    input  wire cordic_lane_t roll_in,
    input  wire cordic_lane_t pitch_in,
    output logic              valid_out,
    output cordic_lane_t      roll_out,
    output cordic_lane_t      pitch_out
);

    function automatic cordic_lane_t rotate(cordic_lane_t l);
        cordic_lane_t r;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        dx = $signed(l.y) >>> STEP;
        dy = $signed(l.x) >>> STEP;
        r = l;
        if (!l.y[31])
        begin
            r.x = l.x + dx;
            r.y = l.y - dy;
            r.z = l.z + atan_step(STEP);
        end
        else
        begin
            r.x = l.x - dx;
            r.y = l.y + dy;
            r.z = l.z - atan_step(STEP);
        end
        return r;
    endfunction

    logic         valid_reg;
    cordic_lane_t roll_reg;
    cordic_lane_t pitch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (valid_in)
        begin
            roll_reg  <= rotate(roll_in);
            pitch_reg <= rotate(pitch_in);
        end
    end

    assign valid_out = valid_reg;
    assign roll_out  = roll_reg;
    assign pitch_out = pitch_reg;

endmodule

`default_nettype wire

>>> design/ictf_mul.sv
// ictf_mul: shared registered signed multiplier with a result tag
// depends on ictf_pkg
`default_nettype none

module ictf_mul
    import ictf_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     issue,
    input  wire mul_tag_t                 tag_in,
    input  wire logic signed [31:0]       a,
    input  wire logic signed [20:0]       b,
    output logic                          done,
    output mul_tag_t                      tag_out,
    output logic signed [PROD_W-1:0]      product
);

    logic                     done_reg;
    mul_tag_t                 tag_reg;
    logic signed [PROD_W-1:0] product_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= issue;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            tag_reg     <= tag_in;
            product_reg <= PROD_W'(a) * PROD_W'(b);
        end
    end

    assign done    = done_reg;
    assign tag_out = tag_reg;
    assign product = product_reg;

endmodule

`default_nettype wire

>>> design/imu_complementary_tilt_filter_core.sv
// imu_complementary_tilt_filter_core: top level of the complementary tilt filter
// depends on ictf_pkg, ictf_cordic_cell, ictf_mul
//
// usage
//   input channel: one raw 6-axis sample per item, taken at a clock edge with
//   in_valid high and in_stall low
//   output channel: one item per input item with the fused roll, pitch and yaw
//   estimates, signed q10.16 degrees, and the accelerometer-only roll and pitch,
//   signed q9.16 degrees, handed over when out_valid is high and out_stall low
//   config port: cfg_write with cfg_index 0 sets blend_weight (q0.16), index 1
//   sets gyro_step_scale (q0.24); other indexes are ignored
//   processing: from accept to out_valid an item passes the cordic cells, the
//   rounding register, the wait state that starts the blends, the three blend
//   products from the shared multiplier, the last estimate write and the output
//   load; the three gyro passes run alongside the cordic chain and add nothing
//   intake: a new item is taken only in the idle state, entered after the
//   output load; in_stall is high from accept until then
//   a finished result waits in the output register while out_stall is high;
//   the next item is accepted meanwhile and its result waits for the register
//   reset clears the estimates, loads the register defaults, empties the output
`default_nettype none

module imu_complementary_tilt_filter_core
    import ictf_pkg::*;
#(
    parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write,
    input  wire logic [1:0]               cfg_index,
    input  wire logic [19:0]              cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic signed [15:0]       accel_x,
    input  wire logic signed [15:0]       accel_y,
    input  wire logic signed [15:0]       accel_z,
    input  wire logic signed [15:0]       gyro_x,
    input  wire logic signed [15:0]       gyro_y,
    input  wire logic signed [15:0]       gyro_z,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [EST_W-1:0]       roll_angle,
    output logic signed [EST_W-1:0]       pitch_angle,
    output logic signed [EST_W-1:0]       yaw_angle,
    output logic signed [ACC_W-1:0]       accel_roll,
    output logic signed [ACC_W-1:0]       accel_pitch
);

    // configuration registers
    logic [15:0] blend_weight_reg;
    logic [19:0] gyro_step_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_weight_reg    <= 16'd58327;
            gyro_step_scale_reg <= 20'd5115;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BLEND_WEIGHT:    blend_weight_reg    <= cfg_data[15:0];
                REG_GYRO_STEP_SCALE: gyro_step_scale_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // control
    ictf_state_t state_reg;
    ictf_state_t state_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        in_accept;
    logic        out_free;
    logic        out_load;

    // held item and working values
    logic signed [15:0]      gyro_reg [3];
    logic signed [G_W-1:0]   g_reg [3];
    logic signed [EST_W-1:0] est_reg [3];

    // cordic chain, index 0 is the launch register
    logic         launch_valid_reg;
    cordic_lane_t launch_roll_reg;
    cordic_lane_t launch_pitch_reg;
    logic         chain_valid [CORDIC_STEPS+1];
    cordic_lane_t chain_roll  [CORDIC_STEPS+1];
    cordic_lane_t chain_pitch [CORDIC_STEPS+1];

    logic                    acc_valid_reg;
    logic signed [ACC_W-1:0] acc_roll_reg;
    logic signed [ACC_W-1:0] acc_pitch_reg;

    // multiplier signals
    logic                     mul_issue;
    mul_tag_t                 mul_tag;
    logic signed [31:0]       mul_a;
    logic signed [20:0]       mul_b;
    logic                     mul_done;
    mul_tag_t                 mul_tag_done;
    logic signed [PROD_W-1:0] mul_prod;

    // output register
    logic                    out_valid_reg;
    logic signed [EST_W-1:0] roll_angle_reg;
    logic signed [EST_W-1:0] pitch_angle_reg;
    logic signed [EST_W-1:0] yaw_angle_reg;
    logic signed [ACC_W-1:0] accel_roll_reg;
    logic signed [ACC_W-1:0] accel_pitch_reg;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == ST_OUT) && out_free;

    // state machine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cnt_next = 2'd0;
                if (in_valid)
                    state_next = ST_GYRO;
            end
            ST_GYRO:
            begin
                if (cnt_reg == 2'd2)
                begin
                    cnt_next   = 2'd0;
                    state_next = ST_WAIT;
                end
                else
                    cnt_next = cnt_reg + 2'd1;
            end
            ST_WAIT:
            begin
                if (acc_valid_reg)
                    state_next = ST_BLEND;
            end
            ST_BLEND:
            begin
                if (cnt_reg == 2'd2)
                begin
                    cnt_next   = 2'd0;
                    state_next = ST_LAST;
                end
                else
                    cnt_next = cnt_reg + 2'd1;
            end
            ST_LAST:
                state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // capture the item and launch both atan2 lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            launch_valid_reg <= 1'b0;
        else
            launch_valid_reg <= in_accept;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            gyro_reg[0]      <= gyro_x;
            gyro_reg[1]      <= gyro_y;
            gyro_reg[2]      <= gyro_z;
            // roll = atan2(ay, az), pitch = atan2(-ax, az)
            launch_roll_reg  <= cordic_init(17'(accel_y), 17'(accel_z));
            launch_pitch_reg <= cordic_init(-17'(accel_x), 17'(accel_z));
        end
    end

    assign chain_valid[0] = launch_valid_reg;
    assign chain_roll[0]  = launch_roll_reg;
    assign chain_pitch[0] = launch_pitch_reg;

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cell
        ictf_cordic_cell #(
            .STEP (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (chain_valid[k]),
            .roll_in   (chain_roll[k]),
            .pitch_in  (chain_pitch[k]),
            .valid_out (chain_valid[k+1]),
            .roll_out  (chain_roll[k+1]),
            .pitch_out (chain_pitch[k+1])
        );
    end

    // final rounding and clamp of the accelerometer angles
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_valid_reg <= 1'b0;
        else
            acc_valid_reg <= chain_valid[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (chain_valid[CORDIC_STEPS])
        begin
            acc_roll_reg  <= cordic_finish(chain_roll[CORDIC_STEPS]);
            acc_pitch_reg <= cordic_finish(chain_pitch[CORDIC_STEPS]);
        end
    end

    // multiplier issue: gyro steps first, then the three blends
    // blend is folded as a + w * (g - a), yaw blends against zero
    logic signed [ACC_W-1:0] acc_issue;
    logic signed [30:0]      blend_diff;

    always_comb
    begin
        case (cnt_reg)
            2'd0:    acc_issue = acc_roll_reg;
            2'd1:    acc_issue = acc_pitch_reg;
            default: acc_issue = '0;
        endcase
    end

    assign blend_diff = 31'(g_reg[cnt_reg]) - 31'(acc_issue);

    always_comb
    begin
        mul_issue    = 1'b0;
        mul_tag.op   = OP_GYRO;
        mul_tag.axis = cnt_reg;
        mul_a        = 32'(gyro_reg[cnt_reg]);
        mul_b        = $signed({1'b0, gyro_step_scale_reg});
        if (state_reg == ST_GYRO)
            mul_issue = 1'b1;
        else if (state_reg == ST_BLEND)
        begin
            mul_issue  = 1'b1;
            mul_tag.op = OP_BLEND;
            mul_a      = 32'(blend_diff);
            mul_b      = $signed({5'd0, blend_weight_reg});
        end
    end

    ictf_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .issue   (mul_issue),
        .tag_in  (mul_tag),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .tag_out (mul_tag_done),
        .product (mul_prod)
    );

    // multiplier results: gyro angle or new estimate
    logic signed [PROD_W-1:0] step_wide;
    logic signed [PROD_W-1:0] blend_wide;
    logic signed [G_W-1:0]    step_q;
    logic signed [G_W-1:0]    blend_q;
    logic signed [ACC_W-1:0]  acc_done;
    logic signed [30:0]       est_sum;
    logic signed [EST_W-1:0]  est_sat;

    assign step_wide  = (mul_prod + (PROD_W'(1) <<< (STEP_SHIFT - 1))) >>> STEP_SHIFT;
    assign blend_wide = (mul_prod + (PROD_W'(1) <<< (WEIGHT_FRAC - 1))) >>> WEIGHT_FRAC;
    assign step_q     = step_wide[G_W-1:0];
    assign blend_q    = blend_wide[G_W-1:0];

    always_comb
    begin
        case (mul_tag_done.axis)
            2'd0:    acc_done = acc_roll_reg;
            2'd1:    acc_done = acc_pitch_reg;
            default: acc_done = '0;
        endcase
    end

    assign est_sum = 31'(acc_done) + 31'(blend_q);

    // saturate at +-360 degrees
    always_comb
    begin
        if (est_sum > EST_LIM)
            est_sat = EST_W'(EST_LIM);
        else if (est_sum < -EST_LIM)
            est_sat = EST_W'(-EST_LIM);
        else
            est_sat = est_sum[EST_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mul_done && (mul_tag_done.op == OP_GYRO))
            g_reg[mul_tag_done.axis] <= G_W'(est_reg[mul_tag_done.axis]) + step_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg[0] <= '0;
            est_reg[1] <= '0;
            est_reg[2] <= '0;
        end
        else if (mul_done && (mul_tag_done.op == OP_BLEND))
            est_reg[mul_tag_done.axis] <= est_sat;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            roll_angle_reg  <= est_reg[0];
            pitch_angle_reg <= est_reg[1];
            yaw_angle_reg   <= est_reg[2];
            accel_roll_reg  <= acc_roll_reg;
            accel_pitch_reg <= acc_pitch_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign roll_angle  = roll_angle_reg;
    assign pitch_angle = pitch_angle_reg;
    assign yaw_angle   = yaw_angle_reg;
    assign accel_roll  = accel_roll_reg;
    assign accel_pitch = accel_pitch_reg;

endmodule

`default_nettype wire

>>> design/ictf_checker.sv
// ictf_checker: port-level assertions on the tilt filter top level, with its bind
// depends on imu_complementary_tilt_filter_core
`default_nettype none

module ictf_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic signed [25:0] roll_angle
);

    // block goes busy right after an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accept");

    // work on an item spans at least the shortest cordic chain
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> ##8 in_stall)
        else $error("item finished too early");

    // a new result appears together with the block going idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result delivered while still busy");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(roll_angle)))
        else $error("stalled result changed");

endmodule

bind imu_complementary_tilt_filter_core ictf_checker u_ictf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .roll_angle (roll_angle)
);

`default_nettype wire
